>>> hw/rtl/spe_pkg.sv
package spe_pkg;

    localparam int XY_W  = 34;
    localparam int Z_W   = 33;
    localparam int ANG_W = 32;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_vec_t;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [Z_W-1:0]  Z_OFFSET    = 33'sd536870912;

    localparam longint AU_M     = 64'sd149597870700;
    localparam longint RANGE0_L = AU_M + (AU_M * 140612 + 500000000) / 1000000000;
    localparam longint RANGE1_L = (AU_M * 16708617 + 500000000) / 1000000000;
    localparam longint RANGE2_L = (AU_M * 139589 + 500000000) / 1000000000;

    localparam logic signed [39:0] RANGE0_M = 40'(RANGE0_L);
    localparam logic signed [32:0] RANGE1_M = 33'(RANGE1_L);
    localparam logic signed [32:0] RANGE2_M = 33'(RANGE2_L);

    // floor(num * 2^bits / den), restoring long division at elaboration
    function automatic logic [63:0] frac_fix(logic [63:0] num, logic [63:0] den, int bits);
        logic [63:0] rem;
        logic [63:0] q;
        rem = num;
        q   = '0;
        for (int i = 0; i < 64; i++) begin
            if (i < bits) begin
                rem = {rem[62:0], 1'b0};
                q   = {q[62:0], 1'b0};
                if (rem >= den) begin
                    rem  = rem - den;
                    q[0] = 1'b1;
                end
            end
        end
        return q;
    endfunction

    localparam logic [63:0] LON_BASE  = frac_fix(64'd280460, 64'd360000, 64);
    localparam logic [63:0] ANOM_BASE = frac_fix(64'd3575291092, 64'd3600000000, 64);
    localparam logic [63:0] OBL_BASE  = frac_fix(64'd23439291, 64'd360000000, 64);

    localparam logic signed [31:0] LAM_C1 =
        32'(frac_fix(64'd1914666471, 64'd360000000000, 32));
    localparam logic signed [31:0] LAM_C2 =
        32'(frac_fix(64'd19994643, 64'd360000000000, 32));

    // arctangent of 2^-idx in 2^-32 turn
    function automatic logic [31:0] atan_entry(int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/sun_position_eci.sv
// Sun position in the geocentric inertial frame from a time sample.
// Input channel s_*: one transaction carries days since J2000 (signed,
// TIME_FRAC_BITS fraction bits). Output channel m_*: one transaction per
// input carrying the x, y and z position in whole meters.
// The block is a single pipeline: one input is taken every cycle while the
// output side accepts. The pipeline is made of the two CORDIC cell rows in
// series (mean anomaly, then ecliptic longitude), each TRIG_ITERATIONS + 2
// stages, plus the rate multipliers and three rounds of two-stage Q30
// multipliers.
// When m_tready is low while a result is shown, the whole pipeline holds and
// s_tready drops; nothing is lost. Items in flight are independent, so the
// block keeps no state between items.
// Reset (aresetn low, synchronous) clears the valid flags of all stages; the
// block is ready in the cycle after reset is released.
module sun_position_eci #(
    parameter int TIME_FRAC_BITS  = 16,
    parameter int TRIG_ITERATIONS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // days_since_epoch[36:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata    // pos_x[38:0], pos_y[77:39], pos_z[116:78]
);

    localparam int RB  = 64 - TIME_FRAC_BITS;
    localparam int L   = TRIG_ITERATIONS + 2;
    localparam int LAT = 10 + 2 * L;

    localparam logic [63:0] RATE [3] = '{
        spe_pkg::frac_fix(64'd36000771, 64'd13149000000, RB),
        spe_pkg::frac_fix(64'd3599905034, 64'd1314900000000, RB),
        spe_pkg::frac_fix(64'd130042, 64'd131490000000000, RB)
    };

    logic en;
    logic [LAT-1:0] vld_reg, vld_next;

    logic signed [36:0] d_reg;
    logic [63:0] plo_reg [3];
    logic [63:0] plo_next [3];
    logic [31:0] phi_reg [3];
    logic [31:0] phi_next [3];
    logic signed [69:0] plo_full [3];
    logic [63:0] lon_next, anom_next, obl_next;
    logic [31:0] lon_reg, anom_reg, obl_reg;

    logic signed [spe_pkg::XY_W-1:0] cm, sm, c2m, s2m, cl, sl, ce, se, ce_d, se_d;
    logic [31:0] lon_d, obl_d;
    logic [31:0] lam1, lam2;
    logic signed [39:0] rm1, rm2;
    logic [31:0] lam_reg, lam_next;
    logic signed [39:0] r_reg, r_next, r_d;
    logic signed [39:0] x40, ry;
    logic signed [38:0] x_d, y39, z39;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // angle = base + d * rate mod one turn (obliquity: base - d * rate), rate split into 32-bit halves
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            plo_full[k] = d_reg * $signed({1'b0, RATE[k][31:0]});
            plo_next[k] = plo_full[k][63:0];
            phi_next[k] = d_reg[31:0] * RATE[k][63:32];
        end
        lon_next  = spe_pkg::LON_BASE + plo_reg[0] + {phi_reg[0], 32'd0};
        anom_next = spe_pkg::ANOM_BASE + plo_reg[1] + {phi_reg[1], 32'd0};
        obl_next  = spe_pkg::OBL_BASE - (plo_reg[2] + {phi_reg[2], 32'd0});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg    <= $signed(s_tdata[36:0]);
            for (int k = 0; k < 3; k++) begin
                plo_reg[k] <= plo_next[k];
                phi_reg[k] <= phi_next[k];
            end
            lon_reg  <= lon_next[63:32];
            anom_reg <= anom_next[63:32];
            obl_reg  <= obl_next[63:32];
            lam_reg  <= lam_next;
            r_reg    <= r_next;
        end
    end

    spe_cordic #(.ITER(TRIG_ITERATIONS)) u_cordic_m (
        .aclk (aclk), .en (en), .ang (anom_reg), .cos_out (cm), .sin_out (sm)
    );

    spe_cordic #(.ITER(TRIG_ITERATIONS)) u_cordic_2m (
        .aclk (aclk), .en (en), .ang ({anom_reg[30:0], 1'b0}),
        .cos_out (c2m), .sin_out (s2m)
    );

    spe_dly #(.W(32), .D(L + 2)) u_dly_lon (
        .aclk (aclk), .en (en), .din (lon_reg), .dout (lon_d)
    );

    spe_dly #(.W(32), .D(L + 3)) u_dly_obl (
        .aclk (aclk), .en (en), .din (obl_reg), .dout (obl_d)
    );

    spe_mulq30 #(.A_W(spe_pkg::XY_W), .B_W(32), .R_W(32)) u_mul_lam1 (
        .aclk (aclk), .en (en), .a (sm), .b (spe_pkg::LAM_C1), .r (lam1)
    );

    spe_mulq30 #(.A_W(spe_pkg::XY_W), .B_W(32), .R_W(32)) u_mul_lam2 (
        .aclk (aclk), .en (en), .a (s2m), .b (spe_pkg::LAM_C2), .r (lam2)
    );

    spe_mulq30 #(.A_W(33), .B_W(spe_pkg::XY_W), .R_W(40)) u_mul_r1 (
        .aclk (aclk), .en (en), .a (spe_pkg::RANGE1_M), .b (cm), .r (rm1)
    );

    spe_mulq30 #(.A_W(33), .B_W(spe_pkg::XY_W), .R_W(40)) u_mul_r2 (
        .aclk (aclk), .en (en), .a (spe_pkg::RANGE2_M), .b (c2m), .r (rm2)
    );

    always_comb begin
        lam_next = lon_d + lam1 + lam2;
        r_next   = spe_pkg::RANGE0_M - rm1 - rm2;
    end

    spe_cordic #(.ITER(TRIG_ITERATIONS)) u_cordic_lam (
        .aclk (aclk), .en (en), .ang (lam_reg), .cos_out (cl), .sin_out (sl)
    );

    spe_cordic #(.ITER(TRIG_ITERATIONS)) u_cordic_eps (
        .aclk (aclk), .en (en), .ang (obl_d), .cos_out (ce), .sin_out (se)
    );

    spe_dly #(.W(40), .D(L)) u_dly_r (
        .aclk (aclk), .en (en), .din (r_reg), .dout (r_d)
    );

    spe_mulq30 #(.A_W(40), .B_W(spe_pkg::XY_W), .R_W(40)) u_mul_x (
        .aclk (aclk), .en (en), .a (r_d), .b (cl), .r (x40)
    );

    spe_mulq30 #(.A_W(40), .B_W(spe_pkg::XY_W), .R_W(40)) u_mul_ry (
        .aclk (aclk), .en (en), .a (r_d), .b (sl), .r (ry)
    );

    spe_dly #(.W(spe_pkg::XY_W), .D(2)) u_dly_ce (
        .aclk (aclk), .en (en), .din (ce), .dout (ce_d)
    );

    spe_dly #(.W(spe_pkg::XY_W), .D(2)) u_dly_se (
        .aclk (aclk), .en (en), .din (se), .dout (se_d)
    );

    spe_dly #(.W(39), .D(2)) u_dly_x (
        .aclk (aclk), .en (en), .din (x40[38:0]), .dout (x_d)
    );

    spe_mulq30 #(.A_W(40), .B_W(spe_pkg::XY_W), .R_W(39)) u_mul_y (
        .aclk (aclk), .en (en), .a (ry), .b (ce_d), .r (y39)
    );

    spe_mulq30 #(.A_W(40), .B_W(spe_pkg::XY_W), .R_W(39)) u_mul_z (
        .aclk (aclk), .en (en), .a (ry), .b (se_d), .r (z39)
    );

    assign m_tdata = {3'b000, z39, y39, x_d};

endmodule

>>> hw/rtl/spe_dly.sv
module spe_dly #(
    parameter int W = 32,
    parameter int D = 2
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [D];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= din;
            for (int i = 1; i < D; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[D-1];

endmodule

>>> hw/rtl/spe_mulq30.sv
// round half up of a * b / 2^30, two stages, product split at bit 20 of a
module spe_mulq30 #(
    parameter int A_W = 40,
    parameter int B_W = 34,
    parameter int R_W = 40
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [A_W-1:0] a,
    input  logic signed [B_W-1:0] b,
    output logic signed [R_W-1:0] r
);

    localparam int PW = A_W + B_W + 1;

    logic signed [A_W-20+B_W-1:0] ph_reg, ph_next;
    logic signed [B_W+20:0]       pl_reg, pl_next;
    logic signed [PW-1:0]         sum;
    logic signed [R_W-1:0]        r_reg, r_next;

    always_comb begin
        ph_next = $signed(a[A_W-1:20]) * b;
        pl_next = $signed({1'b0, a[19:0]}) * b;
        sum     = (PW'(ph_reg) <<< 20) + PW'(pl_reg) + PW'(64'sd536870912);
        r_next  = R_W'(sum >>> 30);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ph_reg <= ph_next;
            pl_reg <= pl_next;
            r_reg  <= r_next;
        end
    end

    assign r = r_reg;

endmodule

>>> hw/rtl/spe_cordic_cell.sv
module spe_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                aclk,
    input  logic                en,
    input  spe_pkg::cordic_vec_t vec_in,
    output spe_pkg::cordic_vec_t vec_out
);

    localparam logic signed [spe_pkg::Z_W-1:0] ATAN =
        spe_pkg::Z_W'(spe_pkg::atan_entry(IDX));

    spe_pkg::cordic_vec_t vec_reg, vec_next;
    logic signed [spe_pkg::XY_W-1:0] dx, dy;

    always_comb begin
        dx = vec_in.y >>> IDX;
        dy = vec_in.x >>> IDX;
        if (!vec_in.z[spe_pkg::Z_W-1]) begin
            vec_next.x = vec_in.x - dx;
            vec_next.y = vec_in.y + dy;
            vec_next.z = vec_in.z - ATAN;
        end else begin
            vec_next.x = vec_in.x + dx;
            vec_next.y = vec_in.y - dy;
            vec_next.z = vec_in.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg <= vec_next;
        end
    end

    assign vec_out = vec_reg;

endmodule

>>> hw/rtl/spe_cordic.sv
// sine and cosine of a 2^-32 turn angle, ITER + 2 stages
module spe_cordic #(
    parameter int ITER = 32
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic [spe_pkg::ANG_W-1:0]        ang,
    output logic signed [spe_pkg::XY_W-1:0]  cos_out,
    output logic signed [spe_pkg::XY_W-1:0]  sin_out
);

    spe_pkg::cordic_vec_t vec [ITER+1];
    spe_pkg::cordic_vec_t vec0_reg, vec0_next;
    spe_pkg::quad_t       quad_reg [ITER+1];
    spe_pkg::quad_t       quad_next;
    logic [spe_pkg::ANG_W-1:0] a_rot;
    logic signed [spe_pkg::XY_W-1:0] c_reg, c_next, s_reg, s_next;

    // rotate by an eighth turn so the residual angle sits in [-1/8, 1/8)
    always_comb begin
        a_rot       = ang + 32'h2000_0000;
        quad_next   = spe_pkg::quad_t'(a_rot[31:30]);
        vec0_next.x = spe_pkg::CORDIC_GAIN;
        vec0_next.y = '0;
        vec0_next.z = $signed({3'b000, a_rot[29:0]}) - spe_pkg::Z_OFFSET;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec0_reg    <= vec0_next;
            quad_reg[0] <= quad_next;
            for (int i = 1; i <= ITER; i++) begin
                quad_reg[i] <= quad_reg[i-1];
            end
            c_reg <= c_next;
            s_reg <= s_next;
        end
    end

    assign vec[0] = vec0_reg;

    for (genvar g = 0; g < ITER; g++) begin : g_cell
        spe_cordic_cell #(.IDX(g)) u_cell (
            .aclk    (aclk),
            .en      (en),
            .vec_in  (vec[g]),
            .vec_out (vec[g+1])
        );
    end

    always_comb begin
        case (quad_reg[ITER])
            spe_pkg::QUAD_0: begin
                c_next = vec[ITER].x;
                s_next = vec[ITER].y;
            end
            spe_pkg::QUAD_1: begin
                c_next = -vec[ITER].y;
                s_next = vec[ITER].x;
            end
            spe_pkg::QUAD_2: begin
                c_next = -vec[ITER].x;
                s_next = -vec[ITER].y;
            end
            default: begin
                c_next = vec[ITER].y;
                s_next = -vec[ITER].x;
            end
        endcase
    end

    assign cos_out = c_reg;
    assign sin_out = s_reg;

endmodule
